// ===== sv/mir_pkg.sv =====
// Package: shared types, constants and SHA-256 functions for the Merkle root block.
`timescale 1ns / 1ps
package mir_pkg;

   localparam int MaxLevelsDefault = 64;

   typedef enum logic [1:0] {
      CMD_LEAF   = 2'd0,
      CMD_SIB    = 2'd1,
      CMD_FINISH = 2'd2,
      CMD_BAD    = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_SHORT = 2'd1,
      ST_ERR   = 2'd2
   } status_type;

   localparam logic CSR_LEAF_POS  = 1'b0;
   localparam logic CSR_TREE_SIZE = 1'b1;

   typedef enum logic [2:0] {
      S_IDLE,
      S_LOAD,
      S_ROUND,
      S_ADD,
      S_EMIT
   } state_type;

   // start / first flag between controller and compression unit
   typedef struct packed {
      logic start;
      logic first;
   } hctl_type;

   typedef logic [31:0] k_table_type [64];

   localparam k_table_type ShaK = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   localparam logic [255:0] ShaInit = {
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
      return (x >> n) | (x << (32 - n));
   endfunction

endpackage

// ===== sv/merkle_inclusion_root.sv =====
// Top level: RFC 6962 inclusion-proof root folding with a shared SHA-256 unit.
`timescale 1ns / 1ps
// Usage:
//  Write leaf_position (index 0) and tree_size (index 1) over the csr_ channel
//  while idle. Then issue commands with start while busy is low:
//  four leaf words (cmd 0), then four words per sibling (cmd 1), then finish
//  (cmd 2). Each word is taken when start is high while busy is low. The fourth
//  word of a sibling starts a fold: a load state, then two 64-round
//  compressions on the shared SHA-256 unit, each with a start state and a
//  wait for done; busy stays high until the fold has ended.
//  Finish emits four root words on rsp_ from the emit state entered once it is taken,
//  marked by rsp_valid, rsp_is_last on the fourth; busy is high meanwhile.
//  The receiver cannot stall: each word is shown for one cycle only.
//  Synchronous reset clears control state but for the swap and status registers;
//  configuration returns to leaf_position 0, tree_size 1. No clearing pass is needed.
module merkle_inclusion_root #(
   parameter int MAX_PROOF_LEVELS = mir_pkg::MaxLevelsDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_cmd,
   input  logic [63:0] req_hash_word,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [62:0] csr_data,
   output logic        rsp_valid,
   output logic [63:0] rsp_root_word,
   output logic        rsp_is_last,
   output logic [1:0]  rsp_status
);
   import mir_pkg::*;

   logic [62:0] pos_ff, size_ff;
   logic [63:0] run_ff [4];
   logic [63:0] sib_ff [4];
   logic [1:0]  wc_ff, wc_in;
   logic [6:0]  lvl_ff, lvl_in;
   logic        leaf_ff, leaf_in, err_ff, err_in;
   logic        blk_ff, blk_in;
   logic        swap_ff, swap_in;
   logic [1:0]  ec_ff, ec_in;
   logic [1:0]  st_ff, st_in;
   state_type   state_ff, state_in;
   hctl_type    hctl;
   logic        hdone;
   logic [255:0] digest;
   logic [511:0] blk;
   logic [255:0] lft, rgt;
   logic [62:0]  xv;
   logic [6:0]   ipl;
   logic         acc;

   assign csr_ready = 1'b1;
   assign busy = state_ff != S_IDLE;
   assign acc = start && !busy;

   // bit length of position xor (size - 1)
   always_comb begin
      xv  = pos_ff ^ (size_ff - 63'd1);
      ipl = '0;
      for (int i = 0; i < 63; i++)
         if (xv[i]) ipl = 7'(i + 1);
   end

   // message blocks of 0x01 || left || right with padding for 520 bits
   always_comb begin
      lft = {run_ff[0], run_ff[1], run_ff[2], run_ff[3]};
      rgt = {sib_ff[0], sib_ff[1], sib_ff[2], sib_ff[3]};
      if (swap_ff) begin
         lft = {sib_ff[0], sib_ff[1], sib_ff[2], sib_ff[3]};
         rgt = {run_ff[0], run_ff[1], run_ff[2], run_ff[3]};
      end
      if (!blk_ff)
         blk = {8'h01, lft, rgt[255:8]};
      else
         blk = {rgt[7:0], 8'h80, 480'd0, 16'h0208};
   end

   // command sequencer
   always_comb begin
      state_in = state_ff;
      wc_in = wc_ff; lvl_in = lvl_ff; leaf_in = leaf_ff; err_in = err_ff;
      blk_in = blk_ff; swap_in = swap_ff; ec_in = ec_ff; st_in = st_ff;
      hctl = '{start: 1'b0, first: 1'b0};
      case (state_ff)
         S_IDLE: begin
            if (acc) begin
               case (cmd_type'(req_cmd))
                  CMD_LEAF: begin
                     if (leaf_ff) err_in = 1'b1;
                     else begin
                        wc_in = wc_ff + 2'd1;
                        if (wc_ff == 2'd3) leaf_in = 1'b1;
                     end
                  end
                  CMD_SIB: begin
                     if (!leaf_ff) err_in = 1'b1;
                     else begin
                        wc_in = wc_ff + 2'd1;
                        if (wc_ff == 2'd3) begin
                           if (32'(lvl_ff) >= MAX_PROOF_LEVELS) err_in = 1'b1;
                           else state_in = S_LOAD;
                        end
                     end
                  end
                  CMD_FINISH: begin
                     if (err_ff || !leaf_ff || wc_ff != 2'd0) st_in = ST_ERR;
                     else if (ipl > lvl_ff) st_in = ST_SHORT;
                     else st_in = ST_OK;
                     ec_in = '0;
                     state_in = S_EMIT;
                  end
                  default: err_in = 1'b1;
               endcase
            end
         end
         S_LOAD: begin
            swap_in = !(lvl_ff < ipl && pos_ff[lvl_ff[5:0]] == 1'b0);
            blk_in = 1'b0;
            state_in = S_ROUND;
         end
         S_ROUND: begin
            hctl = '{start: 1'b1, first: !blk_ff};
            state_in = S_ADD;
         end
         S_ADD: begin
            if (hdone) begin
               if (!blk_ff) begin
                  blk_in = 1'b1;
                  state_in = S_ROUND;
               end else begin
                  lvl_in = lvl_ff + 7'd1;
                  state_in = S_IDLE;
               end
            end
         end
         S_EMIT: begin
            ec_in = ec_ff + 2'd1;
            if (ec_ff == 2'd3) begin
               wc_in = '0; lvl_in = '0; leaf_in = 1'b0; err_in = 1'b0;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   mir_sha_core u_core (
      .clock  (clock),
      .reset  (reset),
      .ctl    (hctl),
      .block  (blk),
      .done   (hdone),
      .digest (digest)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         wc_ff <= '0; lvl_ff <= '0; leaf_ff <= 1'b0; err_ff <= 1'b0;
         blk_ff <= 1'b0; ec_ff <= '0;
         pos_ff <= '0; size_ff <= 63'd1;
      end else begin
         state_ff <= state_in;
         wc_ff <= wc_in; lvl_ff <= lvl_in; leaf_ff <= leaf_in; err_ff <= err_in;
         blk_ff <= blk_in; ec_ff <= ec_in;
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_LEAF_POS) pos_ff <= csr_data;
            else size_ff <= csr_data;
         end
      end
      swap_ff <= swap_in;
      st_ff <= st_in;
      // hash word stores
      if (state_ff == S_IDLE && acc && cmd_type'(req_cmd) == CMD_LEAF && !leaf_ff)
         run_ff[wc_ff] <= req_hash_word;
      if (state_ff == S_IDLE && acc && cmd_type'(req_cmd) == CMD_SIB && leaf_ff)
         sib_ff[wc_ff] <= req_hash_word;
      if (state_ff == S_ADD && hdone && blk_ff) begin
         run_ff[0] <= digest[255:192];
         run_ff[1] <= digest[191:128];
         run_ff[2] <= digest[127:64];
         run_ff[3] <= digest[63:0];
      end
   end

   assign rsp_valid     = state_ff == S_EMIT;
   assign rsp_root_word = (st_ff == ST_OK) ? run_ff[ec_ff] : 64'd0;
   assign rsp_is_last   = ec_ff == 2'd3;
   assign rsp_status    = st_ff;

`ifndef ASSERT_OFF
   a_lvl_cap : assert property (@(posedge clock) disable iff (reset)
      32'(lvl_ff) <= MAX_PROOF_LEVELS)
      else $error("level counter beyond limit");
   a_emit_four : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_last |=> !rsp_valid)
      else $error("extra root word");
   a_clear_after_finish : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_last |=> lvl_ff == 7'd0 && !leaf_ff && !err_ff)
      else $error("state not cleared after finish");
`endif
endmodule

// ===== sv/mir_sha_core.sv =====
// SHA-256 compression unit: one round per cycle over a 16-word schedule window.
`timescale 1ns / 1ps
module mir_sha_core (
   input  logic              clock,
   input  logic              reset,
   input  mir_pkg::hctl_type ctl,
   input  logic [511:0]      block,
   output logic              done,
   output logic [255:0]      digest
);
   import mir_pkg::*;

   logic [255:0] h_ff, h_in;
   logic [255:0] v_ff, v_in;
   logic [511:0] w_ff, w_in;
   logic [5:0]   rnd_ff, rnd_in;
   logic         run_ff, run_in;
   logic         done_ff, done_in;

   logic [31:0] a, b, c, d, e, f, g, hh, t1, t2, wi, s0, s1, wn;

   // one round and one schedule step
   always_comb begin
      {a, b, c, d, e, f, g, hh} = v_ff;
      wi = w_ff[511:480];
      t1 = hh + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
           + ShaK[rnd_ff] + wi;
      t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      s0 = rotr(w_ff[479:448], 7) ^ rotr(w_ff[479:448], 18) ^ (w_ff[479:448] >> 3);
      s1 = rotr(w_ff[63:32], 17) ^ rotr(w_ff[63:32], 19) ^ (w_ff[63:32] >> 10);
      wn = wi + s0 + w_ff[223:192] + s1;

      h_in    = h_ff;
      v_in    = v_ff;
      w_in    = w_ff;
      rnd_in  = rnd_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (ctl.start) begin
         h_in   = ctl.first ? ShaInit : h_ff;
         v_in   = ctl.first ? ShaInit : h_ff;
         w_in   = block;
         rnd_in = '0;
         run_in = 1'b1;
      end else if (run_ff) begin
         v_in   = {t1 + t2, a, b, c, d + t1, e, f, g};
         w_in   = {w_ff[479:0], wn};
         rnd_in = rnd_ff + 6'd1;
         if (rnd_ff == 6'd63) begin
            run_in  = 1'b0;
            done_in = 1'b1;
            h_in = {h_ff[255:224] + t1 + t2, h_ff[223:192] + a, h_ff[191:160] + b,
                    h_ff[159:128] + c, h_ff[127:96] + d + t1, h_ff[95:64] + e,
                    h_ff[63:32] + f, h_ff[31:0] + g};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         rnd_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         rnd_ff  <= rnd_in;
      end
      h_ff <= h_in;
      v_ff <= v_in;
      w_ff <= w_in;
   end

   assign done   = done_ff;
   assign digest = h_ff;

`ifndef ASSERT_OFF
   a_done_after_last : assert property (@(posedge clock) disable iff (reset)
      run_ff && !ctl.start && rnd_ff == 6'd63 |=> done_ff)
      else $error("done missing after round 63");
   a_no_start_busy : assert property (@(posedge clock) disable iff (reset)
      run_ff |-> !ctl.start)
      else $error("compression restarted while running");
   a_done_idle : assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !run_ff)
      else $error("done while still running");
`endif
endmodule
